// File: src/stable_priority_ready_queue_core_assert.svh
// assertion macros for the stable priority ready queue
`ifndef STABLE_PRIORITY_READY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_READY_QUEUE_CORE_ASSERT_SVH

// checked property, quiet while reset is high
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/spq_pkg.sv
// shared types and constants of the stable priority ready queue
`timescale 1ns / 1ps

package spq_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam int ID_W   = 8;
   localparam int PRIO_W = 4;
   localparam int STAT_W = 3;

   // request commands
   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_ENQUEUED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_DEQUEUED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   // one queue slot
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } slot_type;

   // control broadcast to every cell
   typedef struct packed {
      logic              enq;
      logic              deq;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cell_ctl_type;

endpackage

// File: src/spq_cell.sv
// one slot of the sorted shift queue
`timescale 1ns / 1ps

module spq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::slot_type    left_slot,
   input  logic                 left_ge,
   input  spq_pkg::slot_type    right_slot,
   output spq_pkg::slot_type    slot,
   output logic                 ge,
   output logic                 hit
);
   import spq_pkg::*;

   logic              valid_ff;
   logic [ID_W-1:0]   id_ff;
   logic [PRIO_W-1:0] prio_ff;
   slot_type          slot_in;

   assign slot = '{valid: valid_ff, id: id_ff, prio: prio_ff};

   // entry stays ahead of a new one of equal or lower priority
   assign ge  = valid_ff && (prio_ff >= ctl.prio);
   assign hit = valid_ff && (id_ff == ctl.id);

   always_comb begin
      slot_in = slot;
      if (ctl.enq) begin
         if (ge) begin
            slot_in = slot;
         end else if (left_ge) begin
            slot_in = '{valid: 1'b1, id: ctl.id, prio: ctl.prio};
         end else begin
            slot_in = left_slot;
         end
      end else if (ctl.deq) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= slot_in.id;
      prio_ff <= slot_in.prio;
   end

endmodule

// File: src/stable_priority_ready_queue_core.sv
// top level of the stable priority ready queue: cell chain and response register
`timescale 1ns / 1ps

//  channel | direction | ports
//  --------+-----------+---------------------------------------------------------
//  req     | in        | req_valid, req_stall, req_cmd, req_proc_id, req_priority_req
//  rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_out_id, rsp_out_priority
//
//  one request per cycle while req_stall is low; each request is answered in the next cycle by one response
//  the slot chain compares every cell against the request in parallel and shifts
//  in the same cycle, so insert and removal both complete at the edge that accepts the request
//  synchronous reset empties all slots; no clearing pass is needed
//  req_stall rises only while a response waits and rsp_stall holds it

module stable_priority_ready_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [spq_pkg::ID_W-1:0]    req_proc_id,
   input  logic [spq_pkg::PRIO_W-1:0]  req_priority_req,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [spq_pkg::STAT_W-1:0]  rsp_status,
   output logic [spq_pkg::ID_W-1:0]    rsp_out_id,
   output logic [spq_pkg::PRIO_W-1:0]  rsp_out_priority
);
   import spq_pkg::*;

`include "stable_priority_ready_queue_core_assert.svh"

   // chain wiring: cell i sees cell i-1 on its left and cell i+1 on its right
   slot_type     slot_w  [QUEUE_DEPTH];
   logic         ge_w    [QUEUE_DEPTH];
   logic         hit_vec [QUEUE_DEPTH];
   slot_type     left_w  [QUEUE_DEPTH];
   logic         lge_w   [QUEUE_DEPTH];
   slot_type     right_w [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_vec;

   cell_ctl_type ctl;
   logic         req_accept;
   logic         dup;
   logic         full;
   slot_type     head;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_out_id_ff, rsp_out_id_in;
   logic [PRIO_W-1:0] rsp_out_priority_ff, rsp_out_priority_in;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            // head has nothing ahead: a new entry lands here unless the head stays
            assign left_w[gi] = '0;
            assign lge_w[gi]  = 1'b1;
         end else begin : g_body
            assign left_w[gi] = slot_w[gi-1];
            assign lge_w[gi]  = ge_w[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_w[gi] = '0;
         end else begin : g_mid
            assign right_w[gi] = slot_w[gi+1];
         end
         assign valid_vec[gi] = slot_w[gi].valid;

         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .left_slot  (left_w[gi]),
            .left_ge    (lge_w[gi]),
            .right_slot (right_w[gi]),
            .slot       (slot_w[gi]),
            .ge         (ge_w[gi]),
            .hit        (hit_vec[gi])
         );
      end
   endgenerate

   // id already queued anywhere in the chain
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         dup = dup | hit_vec[i];
      end
   end

   // valid slots are a prefix, so the tail tells fullness
   assign full = slot_w[QUEUE_DEPTH-1].valid;
   assign head = slot_w[0];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign ctl.enq  = req_accept && (req_cmd == CMD_ENQ) && !dup && !full;
   assign ctl.deq  = req_accept && (req_cmd == CMD_DEQ) && head.valid;
   assign ctl.id   = req_proc_id;
   assign ctl.prio = req_priority_req;

   // response for this request, from the state before the update
   always_comb begin
      rsp_status_in       = rsp_status_ff;
      rsp_out_id_in       = rsp_out_id_ff;
      rsp_out_priority_in = rsp_out_priority_ff;
      if (req_accept) begin
         rsp_out_id_in       = '0;
         rsp_out_priority_in = '0;
         if (req_cmd == CMD_ENQ) begin
            if (dup) begin
               rsp_status_in = ST_DUPLICATE;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_status_in = ST_ENQUEUED;
            end
         end else if (head.valid) begin
            rsp_status_in       = ST_DEQUEUED;
            rsp_out_id_in       = head.id;
            rsp_out_priority_in = head.prio;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
      end
   end

   // response stays until taken; a new request may replace a taken one at once
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff       <= rsp_status_in;
      rsp_out_id_ff       <= rsp_out_id_in;
      rsp_out_priority_ff <= rsp_out_priority_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;

   // neighbor order: a valid slot never outranks the one ahead of it
   logic [QUEUE_DEPTH-2:0] order_ok;
   generate
      for (gi = 0; gi < QUEUE_DEPTH - 1; gi++) begin : g_order
         assign order_ok[gi] = !slot_w[gi+1].valid ||
                               (slot_w[gi].prio >= slot_w[gi+1].prio);
      end
   endgenerate

   `SPQ_ASSERT_ALWAYS(a_valid_prefix,
      (reset || ((valid_vec & (valid_vec + 1'b1)) == '0)),
      "valid slots are not a prefix")
   `SPQ_ASSERT(a_sorted, (&order_ok), "queue is not sorted by priority")
   `SPQ_ASSERT(a_enq_grows,
      ctl.enq |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1),
      "enqueue did not add exactly one slot")
   `SPQ_ASSERT(a_empty_deq_holds,
      (req_accept && (req_cmd == CMD_DEQ) && !head.valid) |=> (valid_vec == '0),
      "dequeue on empty changed the queue")

endmodule

// File: tb/stable_priority_ready_queue_core_tb.sv
// self-checking testbench of the stable priority ready queue core
`timescale 1ns / 1ps

// one expected or observed response
typedef struct packed {
   logic [spq_pkg::STAT_W-1:0] status;
   logic [spq_pkg::ID_W-1:0]   id;
   logic [spq_pkg::PRIO_W-1:0] prio;
} outcome_type;

// shadow copy of the ready queue plus the responses still owed by the block
class ready_queue_tracker;
   spq_pkg::slot_type held[$];       // slot 0 is the head
   outcome_type       pending[$];    // oldest first
   int                errors;
   int                requests;
   int                responses;
   int                seen[8];       // responses per status code
   int                deepest;

   function new();
      errors    = 0;
      requests  = 0;
      responses = 0;
      deepest   = 0;
      foreach (seen[i]) seen[i] = 0;
   endfunction

   // work out the response of an accepted request and update the shadow queue
   function void note_request(logic cmd, logic [spq_pkg::ID_W-1:0] id,
                              logic [spq_pkg::PRIO_W-1:0] prio);
      outcome_type       want;
      spq_pkg::slot_type entry;
      bit                already;
      int                pos;
      want    = '0;
      already = 1'b0;
      pos     = 0;
      requests++;
      if (cmd == spq_pkg::CMD_ENQ) begin
         foreach (held[i]) if (held[i].id == id) already = 1'b1;
         if (already) begin
            want.status = spq_pkg::ST_DUPLICATE;
         end else if (held.size() >= spq_pkg::QUEUE_DEPTH) begin
            want.status = spq_pkg::ST_FULL;
         end else begin
            // behind every entry of equal or higher priority
            foreach (held[i]) if (held[i].prio >= prio) pos = i + 1;
            entry.valid = 1'b1;
            entry.id    = id;
            entry.prio  = prio;
            held.insert(pos, entry);
            want.status = spq_pkg::ST_ENQUEUED;
            if (held.size() > deepest) deepest = held.size();
         end
      end else begin
         if (held.size() == 0) begin
            want.status = spq_pkg::ST_EMPTY;
         end else begin
            entry       = held.pop_front();
            want.status = spq_pkg::ST_DEQUEUED;
            want.id     = entry.id;
            want.prio   = entry.prio;
         end
      end
      pending.push_back(want);
   endfunction

   // compare an accepted response against the oldest expectation
   function void check_response(logic [spq_pkg::STAT_W-1:0] status,
                                logic [spq_pkg::ID_W-1:0] id,
                                logic [spq_pkg::PRIO_W-1:0] prio);
      outcome_type want;
      responses++;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: response with no request outstanding: status %0d id %0d prio %0d",
                  $time, status, id, prio);
         return;
      end
      want = pending.pop_front();
      seen[want.status]++;
      if (status !== want.status) begin
         errors++;
         $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
      end
      if (id !== want.id) begin
         errors++;
         $display("%0t: out_id mismatch: expected %0d actual %0d", $time, want.id, id);
      end
      if (prio !== want.prio) begin
         errors++;
         $display("%0t: out_priority mismatch: expected %0d actual %0d",
                  $time, want.prio, prio);
      end
   endfunction
endclass

module stable_priority_ready_queue_core_tb;
   import spq_pkg::*;

   localparam int RANDOM_REQUESTS = 1550;
   localparam int CALM_FIRST      = 600;    // no idling on either side in this window
   localparam int CALM_LAST       = 900;
   localparam int IDLE_PCT        = 30;
   localparam int DRAIN_CYCLES    = 8;      // quiet cycles after the drain, to catch stray responses

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_cmd;
   logic [ID_W-1:0]   req_proc_id;
   logic [PRIO_W-1:0] req_priority_req;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [ID_W-1:0]   rsp_out_id;
   logic [PRIO_W-1:0] rsp_out_priority;

   // set by the stimulus while both sides must stay busy
   bit calm = 1'b0;

   ready_queue_tracker tracker;

   stable_priority_ready_queue_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_proc_id      (req_proc_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random back-pressure, none in the calm window
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // both handshakes are taken from values sampled at the same edge, request first,
   // so the outcome never depends on process order within a time step
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_request(req_cmd, req_proc_id, req_priority_req);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_response(rsp_status, rsp_out_id, rsp_out_priority);
         end
      end
   end

   // present one request, with random idle cycles ahead of it, and hold it until taken
   task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio);
      while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_proc_id      <= id;
      req_priority_req <= prio;
      @(posedge clock);
      // stall seen here is the value sampled at this edge
      while (req_stall) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      int               enq_pct;
      bit               narrow_ids;
      bit               wide_prio;
      logic             cmd;
      logic [ID_W-1:0]  id;
      logic [PRIO_W-1:0] prio;

      tracker          = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_ENQ;
      req_proc_id      <= '0;
      req_priority_req <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      // dequeue while nothing is queued
      send_request(CMD_DEQ, 8'd0, 4'd0);
      // id zero is an ordinary id, priority zero and fifteen are stored as given
      send_request(CMD_ENQ, 8'd0, 4'd0);
      send_request(CMD_ENQ, 8'd255, 4'd15);
      // same id again is refused
      send_request(CMD_ENQ, 8'd0, 4'd7);
      // equal priorities must come out in arrival order
      send_request(CMD_ENQ, 8'h55, 4'd10);
      send_request(CMD_ENQ, 8'hAA, 4'd10);
      send_request(CMD_ENQ, 8'h33, 4'd10);
      // fill every remaining slot
      for (int i = 0; i < QUEUE_DEPTH - 5; i++) begin
         send_request(CMD_ENQ, ID_W'(8'h10 + i), PRIO_W'(4 + i % 3));
      end
      // full queue refuses a new id
      send_request(CMD_ENQ, 8'hC3, 4'd1);
      // queued id on a full queue reports the duplicate, not full
      send_request(CMD_ENQ, 8'd255, 4'd3);
      // head order: 255, then the three of priority ten in arrival order
      repeat (4) send_request(CMD_DEQ, 8'hFF, 4'hF);

      // random part: blocks with their own enqueue mix, id pool and priority range
      enq_pct    = 50;
      narrow_ids = 1'b0;
      wide_prio  = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(3))
               0:       enq_pct = 30;
               1:       enq_pct = 50;
               2:       enq_pct = 70;
               default: enq_pct = 90;
            endcase
            // a small pool of ids makes duplicates common
            narrow_ids = 1'($urandom_range(1));
            wide_prio  = ($urandom_range(3) == 0);
         end
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         id   = narrow_ids ? ID_W'($urandom_range(23)) : ID_W'($urandom_range(255));
         prio = wide_prio ? PRIO_W'($urandom_range(15)) : PRIO_W'($urandom_range(10, 1));
         cmd  = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
         send_request(cmd, id, prio);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain outstanding responses, then a few quiet cycles for strays
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d responses, queue reached depth %0d",
               tracker.requests, tracker.responses, tracker.deepest);
      $display("enqueued %0d, already queued %0d, full %0d, dequeued %0d, empty %0d",
               tracker.seen[ST_ENQUEUED], tracker.seen[ST_DUPLICATE], tracker.seen[ST_FULL],
               tracker.seen[ST_DEQUEUED], tracker.seen[ST_EMPTY]);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", tracker.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_ready_queue_core.sv
tb/stable_priority_ready_queue_core_tb.sv
